// ===== src/l2dpr_pkg.sv =====
// Shared constants and types for the 2D Lorenzo predict/restore block.
`default_nettype none
package l2dpr_pkg;

    localparam int MAX_ROW_LENGTH = 1024;
    localparam int DATA_W         = 32;
    localparam int COL_W          = $clog2(MAX_ROW_LENGTH);
    localparam int LEN_W          = 11;
    localparam int CNT_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd2;

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_RESTORE = 1'b1;

    // Effective grid size after clamping.
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
    } t_geom;

    // Position of the word being accepted.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             first_col;
        logic             row_end;
        logic             frame_end;
    } t_pos;

endpackage
`default_nettype wire

// ===== src/lorenzo_2d_predict_restore.sv =====
// 2D Lorenzo predictor / restorer top level with line store and output register.
// Takes one 32-bit word per cycle unless o_stall is high; each accepted word passes the stage-1
// register and then the output register before its result is presented, at a sustained rate of
// one word per clock while the output does not stall. The rate is set by the line-store
// RAM: the entry for the accepted column is read at acceptance, and the prediction
// (left + below - below-left) and the write-back of the original value happen in stage 1,
// with a forwarding path for one-sample rows. The line store needs no clearing pass.
`default_nettype none
module lorenzo_2d_predict_restore (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [l2dpr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [l2dpr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [l2dpr_pkg::DATA_W-1:0]    i_sample_in,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic signed [l2dpr_pkg::DATA_W-1:0]         o_sample_out,
    output logic                                        o_row_end,
    output logic                                        o_frame_end
);

    localparam int DW = l2dpr_pkg::DATA_W;

    // configuration
    logic                            r_mode;
    logic [l2dpr_pkg::LEN_W-1:0]     r_row_length;
    logic [l2dpr_pkg::CNT_W-1:0]     r_row_count;
    l2dpr_pkg::t_geom                geom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= l2dpr_pkg::MODE_PREDICT;
            r_row_length <= l2dpr_pkg::LEN_W'(l2dpr_pkg::MAX_ROW_LENGTH);
            r_row_count  <= l2dpr_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                l2dpr_pkg::CFG_MODE:       r_mode       <= i_cfg_data[0];
                l2dpr_pkg::CFG_ROW_LENGTH: r_row_length <= i_cfg_data[l2dpr_pkg::LEN_W-1:0];
                l2dpr_pkg::CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[l2dpr_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        geom.len = r_row_length;
        if (r_row_length == '0) begin
            geom.len = l2dpr_pkg::LEN_W'(1);
        end else if (r_row_length > l2dpr_pkg::LEN_W'(l2dpr_pkg::MAX_ROW_LENGTH)) begin
            geom.len = l2dpr_pkg::LEN_W'(l2dpr_pkg::MAX_ROW_LENGTH);
        end
        geom.cnt = (r_row_count == '0) ? l2dpr_pkg::CNT_W'(1) : r_row_count;
    end

    // handshake
    logic r_s1_valid, r_out_valid;
    logic out_load, s1_adv, in_accept;

    assign out_load  = r_s1_valid && (!r_out_valid || !i_stall);
    assign s1_adv    = out_load;
    assign o_stall   = r_s1_valid && r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    l2dpr_pkg::t_pos pos;

    l2dpr_pos u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_geom   (geom),
        .o_pos    (pos)
    );

    // stage 1: input register and line-store read data
    logic [DW-1:0]   r_x;
    l2dpr_pkg::t_pos r_pos;
    logic [DW-1:0]   r_rd;
    logic            r_fwd;
    logic [DW-1:0]   r_fwd_data;
    logic [DW-1:0]   r_line [l2dpr_pkg::MAX_ROW_LENGTH];

    logic [DW-1:0]   r_left, r_below_left;
    logic [DW-1:0]   below, pred, result, orig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_x        <= DW'(i_sample_in);
            r_pos      <= pos;
            // forward the word being written when a one-sample row reads it back
            r_fwd      <= s1_adv && (r_pos.col == pos.col);
            r_fwd_data <= orig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd <= r_line[pos.col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_line[r_pos.col] <= orig;
        end
    end

    always_comb begin
        below = r_pos.first_row ? '0 : (r_fwd ? r_fwd_data : r_rd);
        if (r_pos.first_row) begin
            pred = r_pos.first_col ? '0 : r_left;
        end else if (r_pos.first_col) begin
            pred = below;
        end else begin
            pred = r_left + below - r_below_left;
        end
        if (r_mode == l2dpr_pkg::MODE_PREDICT) begin
            result = r_x - pred;
            orig   = r_x;
        end else begin
            result = r_x + pred;
            orig   = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left       <= '0;
            r_below_left <= '0;
        end else if (s1_adv) begin
            r_left       <= orig;
            r_below_left <= below;
        end
    end

    // output register
    logic [DW-1:0] r_out_data;
    logic          r_out_row_end, r_out_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data      <= result;
            r_out_row_end   <= r_pos.row_end;
            r_out_frame_end <= r_pos.frame_end;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = signed'(r_out_data);
    assign o_row_end    = r_out_row_end;
    assign o_frame_end  = r_out_frame_end;

endmodule
`default_nettype wire

// ===== src/l2dpr_pos.sv =====
// Column and row tracker: gives the grid position of each accepted word.
`default_nettype none
module l2dpr_pos (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire l2dpr_pkg::t_geom i_geom,
    output l2dpr_pkg::t_pos     o_pos
);

    logic [l2dpr_pkg::COL_W-1:0] r_col, n_col;
    logic [l2dpr_pkg::CNT_W-1:0] r_row, n_row;

    logic [l2dpr_pkg::COL_W-1:0] cur_col;
    logic [l2dpr_pkg::CNT_W-1:0] cur_row;
    logic                        rend, fend;

    always_comb begin
        cur_col = r_col;
        cur_row = r_row;
        // start a new row or frame if the geometry shrank under the position
        if ({1'b0, r_col} >= i_geom.len) begin
            cur_col = '0;
            cur_row = r_row + 1'b1;
        end
        if (cur_row >= i_geom.cnt) begin
            cur_row = '0;
        end
        rend = ({1'b0, cur_col} == (i_geom.len - 1'b1));
        fend = rend && (cur_row == (i_geom.cnt - 1'b1));

        if (rend) begin
            n_col = '0;
            n_row = fend ? '0 : cur_row + 1'b1;
        end else begin
            n_col = cur_col + 1'b1;
            n_row = cur_row;
        end

        o_pos.col       = cur_col;
        o_pos.first_row = (cur_row == '0);
        o_pos.first_col = (cur_col == '0);
        o_pos.row_end   = rend;
        o_pos.frame_end = fend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule
`default_nettype wire
